// ===== src/hrmr_pkg.sv =====
// hrmr_pkg: types and constants shared by the report message reassembler
// no dependencies
`timescale 1ns / 1ps

package hrmr_pkg;

  // report framing
  localparam int unsigned REPORT_BYTES      = 64;
  localparam int unsigned MAX_CONTINUATIONS = 128;
  localparam int unsigned CHAN_BYTES        = 4;   // bytes 0..3 carry the channel id
  localparam int unsigned CONT_HDR_BYTES    = 5;   // continuation header length
  localparam int unsigned INIT_HDR_BYTES    = 7;   // initialisation header length
  localparam int unsigned LAST_POS          = 63;  // highest byte index a report can reach
  localparam int unsigned MAX_MESSAGE_BYTES =
    (REPORT_BYTES - INIT_HDR_BYTES) + MAX_CONTINUATIONS * (REPORT_BYTES - CONT_HDR_BYTES);

  // type byte: bit 7 marks an initialisation report
  localparam int unsigned TYPE_INIT_BIT = 7;

  // bit positions in the report kind flags
  localparam int unsigned KIND_INIT     = 0;
  localparam int unsigned KIND_ACTIVE   = 1;
  localparam int unsigned KIND_INREPORT = 2;

  // one input beat
  typedef struct packed {
    logic [7:0] report_byte;
    logic       first_of_report;
    logic [6:0] report_length;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [31:0] channel_id;
    logic [7:0]  command_code;
    logic [12:0] message_length;
    logic [7:0]  payload_byte;
    logic [12:0] byte_offset;
    logic        message_last;
  } result_t;

endpackage

// ===== src/hrmr_if.sv =====
// hrmr_in_if and hrmr_out_if: valid/ready channels of the reassembler
// no dependencies
`timescale 1ns / 1ps

interface hrmr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       first_of_report;
  logic [6:0] report_length;

  modport source (output valid, output report_byte, output first_of_report,
                  output report_length, input ready);
  modport sink   (input valid, input report_byte, input first_of_report,
                  input report_length, output ready);
endinterface

interface hrmr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] channel_id;
  logic [7:0]  command_code;
  logic [12:0] message_length;
  logic [7:0]  payload_byte;
  logic [12:0] byte_offset;
  logic        message_last;

  modport source (output valid, output channel_id, output command_code,
                  output message_length, output payload_byte, output byte_offset,
                  output message_last, input ready);
  modport sink   (input valid, input channel_id, input command_code,
                  input message_length, input payload_byte, input byte_offset,
                  input message_last, output ready);
endinterface

// ===== src/hrmr_in_stage.sv =====
// hrmr_in_stage: input register holding one report byte beat
// depends on hrmr_pkg and hrmr_in_if
`timescale 1ns / 1ps

module hrmr_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  hrmr_in_if.sink         in_i,
  input  logic            slot_free_i,
  output logic            fire_o,
  output hrmr_pkg::item_t item_o
);
  import hrmr_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  // beat moves on when the result slot can take it
  assign fire_o    = valid_q && slot_free_i;
  assign in_i.ready = !valid_q || slot_free_i;
  assign take      = in_i.valid && in_i.ready;
  assign item_o    = item_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.report_byte     <= in_i.report_byte;
      item_q.first_of_report <= in_i.first_of_report;
      item_q.report_length   <= in_i.report_length;
    end
  end

endmodule

// ===== src/hrmr_core.sv =====
// hrmr_core: report parser and message state, one byte per fire
// depends on hrmr_pkg
`timescale 1ns / 1ps

module hrmr_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  hrmr_pkg::item_t   item_i,
  output logic              res_valid_o,
  output hrmr_pkg::result_t res_o
);
  import hrmr_pkg::*;

  logic [31:0] cur_chan_q, cur_chan_d;
  logic [7:0]  cur_cmd_q, cur_cmd_d;
  logic [15:0] decl_len_q, decl_len_d;
  logic [12:0] remain_q, remain_d;
  logic [12:0] offset_q, offset_d;
  logic [7:0]  exp_seq_q, exp_seq_d;
  logic [5:0]  pos_q, pos_d;
  logic [2:0]  kind_q, kind_d;
  logic [31:0] inc_chan_q, inc_chan_d;

  logic [6:0]  rlen;
  logic [6:0]  pos;
  logic        go;
  logic [7:0]  b;
  logic [15:0] len;

  assign b = item_i.report_byte;

  // report length clamped to the report size
  assign rlen = (item_i.report_length > 7'(REPORT_BYTES)) ? 7'(REPORT_BYTES)
                                                          : item_i.report_length;

  // parse one byte
  always_comb begin
    cur_chan_d  = cur_chan_q;
    cur_cmd_d   = cur_cmd_q;
    decl_len_d  = decl_len_q;
    remain_d    = remain_q;
    offset_d    = offset_q;
    exp_seq_d   = exp_seq_q;
    pos_d       = pos_q;
    kind_d      = kind_q;
    inc_chan_d  = inc_chan_q;
    res_valid_o = 1'b0;
    pos         = '0;
    go          = 1'b0;
    len         = {decl_len_q[15:8], b};

    res_o.channel_id     = cur_chan_q;
    res_o.command_code   = cur_cmd_q;
    res_o.message_length = decl_len_q[12:0];
    res_o.payload_byte   = b;
    res_o.byte_offset    = offset_q;
    res_o.message_last   = (remain_q == 13'd1);

    // locate the byte in its report
    if (item_i.first_of_report) begin
      kind_d = '0;
      kind_d[KIND_INREPORT] = 1'b1;
      if (rlen < 7'(CONT_HDR_BYTES)) begin
        // short report closes the message
        remain_d = '0;
        kind_d   = '0;
        pos_d    = '0;
      end else begin
        go = 1'b1;
      end
    end else if (kind_q[KIND_INREPORT]) begin
      if (pos_q >= 6'(LAST_POS)) begin
        kind_d = '0;
      end else begin
        pos = {1'b0, pos_q} + 7'd1;
        go  = 1'b1;
      end
    end

    if (go) begin
      pos_d = pos[5:0];
      if (pos >= rlen) begin
        // past the end of the report
        kind_d = '0;
      end else if (pos < 7'(CHAN_BYTES)) begin
        // channel id bytes, least significant first
        case (pos[1:0])
          2'd0:    inc_chan_d = {24'd0, b};
          2'd1:    inc_chan_d[15:8]  = b;
          2'd2:    inc_chan_d[23:16] = b;
          default: inc_chan_d[31:24] = b;
        endcase
      end else if (pos == 7'(CHAN_BYTES)) begin
        // type byte: command or sequence number
        if (b[TYPE_INIT_BIT]) begin
          if (rlen < 7'(INIT_HDR_BYTES)) begin
            remain_d = '0;
            kind_d   = '0;
          end else begin
            kind_d[KIND_INIT] = 1'b1;
            cur_cmd_d = b;
          end
        end else if (remain_q != '0 && inc_chan_q == cur_chan_q && b == exp_seq_q) begin
          exp_seq_d = exp_seq_q + 8'd1;
          kind_d[KIND_ACTIVE] = 1'b1;
        end
      end else if (kind_q[KIND_INIT] && pos == 7'(CONT_HDR_BYTES)) begin
        // length high byte
        decl_len_d = {b, 8'd0};
      end else if (kind_q[KIND_INIT] && pos == 7'(CONT_HDR_BYTES + 1)) begin
        // length low byte opens or rejects the message
        decl_len_d = len;
        if (len > 16'(MAX_MESSAGE_BYTES)) begin
          remain_d = '0;
          kind_d   = '0;
        end else begin
          cur_chan_d = inc_chan_q;
          exp_seq_d  = '0;
          offset_d   = '0;
          remain_d   = len[12:0];
          kind_d[KIND_ACTIVE] = 1'b1;
        end
      end else if (kind_q[KIND_ACTIVE] && remain_q != '0) begin
        // payload byte
        res_valid_o = 1'b1;
        remain_d    = remain_q - 13'd1;
        offset_d    = offset_q + 13'd1;
      end
    end
  end

  // message and report state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_chan_q <= '0;
      cur_cmd_q  <= '0;
      decl_len_q <= '0;
      remain_q   <= '0;
      offset_q   <= '0;
      exp_seq_q  <= '0;
      pos_q      <= '0;
      kind_q     <= '0;
      inc_chan_q <= '0;
    end else if (fire_i) begin
      cur_chan_q <= cur_chan_d;
      cur_cmd_q  <= cur_cmd_d;
      decl_len_q <= decl_len_d;
      remain_q   <= remain_d;
      offset_q   <= offset_d;
      exp_seq_q  <= exp_seq_d;
      pos_q      <= pos_d;
      kind_q     <= kind_d;
      inc_chan_q <= inc_chan_d;
    end
  end

endmodule

// ===== src/hrmr_out_stage.sv =====
// hrmr_out_stage: result register driving the output channel
// depends on hrmr_pkg and hrmr_out_if
`timescale 1ns / 1ps

module hrmr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              res_valid_i,
  input  hrmr_pkg::result_t res_i,
  output logic              slot_free_o,
  hrmr_out_if.source        out_o
);
  import hrmr_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // slot is free when empty or being drained this cycle
  assign slot_free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = res_valid_i;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (fire_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.channel_id     = res_q.channel_id;
  assign out_o.command_code   = res_q.command_code;
  assign out_o.message_length = res_q.message_length;
  assign out_o.payload_byte   = res_q.payload_byte;
  assign out_o.byte_offset    = res_q.byte_offset;
  assign out_o.message_last   = res_q.message_last;

endmodule

// ===== src/hid_report_message_reassembler_unit.sv =====
// Report message reassembler: one report byte in per cycle, payload bytes out.
// A payload byte passes the input register and the parser into the result register, which drives the output.
// Takes one byte per cycle while the output is not stalled; the parser state updates once per byte.
// Stalls on the output hold the input register and the input channel's ready.
// Reset (asynchronous, active low) closes any message and clears all parser state.
// Depends on hrmr_pkg, hrmr_in_if, hrmr_out_if, hrmr_in_stage, hrmr_core, hrmr_out_stage.
`timescale 1ns / 1ps

module hid_report_message_reassembler_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrmr_in_if.sink    in_i,
  hrmr_out_if.source out_o
);
  import hrmr_pkg::*;

  logic    fire;
  logic    slot_free;
  logic    res_valid;
  item_t   item;
  result_t res;

  // input register
  hrmr_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .slot_free_i (slot_free),
    .fire_o      (fire),
    .item_o      (item)
  );

  // parser and message state
  hrmr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  hrmr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_o       (out_o)
  );

endmodule

// ===== src/hrmr_checker.sv =====
// hrmr_checker: port-level checks on the reassembler output beats
// depends on hrmr_pkg and hid_report_message_reassembler_unit, bound to it below
`timescale 1ns / 1ps

module hrmr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [12:0] message_length_i,
  input logic [12:0] byte_offset_i,
  input logic        message_last_i,
  input logic [7:0]  payload_byte_i
);
  import hrmr_pkg::*;

  // offset stays below the largest message a header may declare
  a_offset_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (byte_offset_i < 13'(MAX_MESSAGE_BYTES)))
    else $error("byte offset beyond the largest message");

  // a beat straight after a final beat starts a new message
  a_new_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && message_last_i) ##1 out_valid_i
    |-> (byte_offset_i == '0))
    else $error("message continued after its final beat");

  // a beat with a nonzero offset that follows a non-final beat continues the message
  a_offset_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !message_last_i) ##1 (out_valid_i && byte_offset_i != '0)
    |-> (byte_offset_i == $past(byte_offset_i) + 13'd1))
    else $error("payload offset skipped or repeated");

  // stalled beat holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(payload_byte_i)
                                       && $stable(byte_offset_i)
                                       && $stable(message_length_i)))
    else $error("stalled beat changed");

endmodule

bind hid_report_message_reassembler_unit hrmr_checker u_hrmr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .message_length_i (out_o.message_length),
  .byte_offset_i    (out_o.byte_offset),
  .message_last_i   (out_o.message_last),
  .payload_byte_i   (out_o.payload_byte)
);

// ===== sim/hid_report_message_reassembler_unit_tb.sv =====
// hid_report_message_reassembler_unit_tb: random and directed test of the report reassembler
// drives report bytes, predicts each payload beat and checks it; needs hrmr_pkg, hrmr_if
`timescale 1ns / 1ps

module hid_report_message_reassembler_unit_tb;
  import hrmr_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_BEATS = 608;

  logic clk_i = 1'b0;
  logic rst_ni;

  hrmr_in_if  in_ch ();
  hrmr_out_if out_ch ();

  hid_report_message_reassembler_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  item_t       pending_beats[$];
  result_t     expected_bytes[$];
  int unsigned errors;
  int unsigned idle_cycles;

  // predicted reassembly state
  logic [31:0] msg_channel;
  logic [7:0]  msg_command;
  logic [15:0] msg_length;
  logic [12:0] msg_left;
  logic [12:0] msg_offset;
  logic [7:0]  next_seq;
  logic [5:0]  rpt_index;
  logic [2:0]  rpt_flags;
  logic [31:0] rpt_channel;

  task automatic note_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // advance the reassembly state by one report byte, queue a payload beat if one results
  task automatic reassemble_beat(input item_t beat);
    int unsigned rlen;
    int unsigned pos;
    logic [15:0] len;
    result_t     res;
    rlen = beat.report_length;
    if (rlen > REPORT_BYTES) rlen = REPORT_BYTES;
    if (beat.first_of_report) begin
      pos = 0;
      rpt_flags = '0;
      rpt_flags[KIND_INREPORT] = 1'b1;
      if (rlen < CONT_HDR_BYTES) begin
        msg_left  = '0;
        rpt_flags = '0;
        rpt_index = '0;
        return;
      end
    end else begin
      if (!rpt_flags[KIND_INREPORT]) return;
      if (rpt_index >= LAST_POS) begin
        rpt_flags = '0;
        return;
      end
      pos = rpt_index + 1;
    end
    rpt_index = pos[5:0];
    if (pos >= rlen) begin
      rpt_flags = '0;
      return;
    end
    // channel id bytes, least significant first
    if (pos < CHAN_BYTES) begin
      if (pos == 0) rpt_channel = '0;
      rpt_channel[8*pos +: 8] = beat.report_byte;
      return;
    end
    // type byte: command or sequence number
    if (pos == CHAN_BYTES) begin
      if (beat.report_byte[TYPE_INIT_BIT]) begin
        if (rlen < INIT_HDR_BYTES) begin
          msg_left  = '0;
          rpt_flags = '0;
          return;
        end
        rpt_flags[KIND_INIT] = 1'b1;
        msg_command = beat.report_byte;
      end else if (msg_left != 0 && rpt_channel == msg_channel &&
                   beat.report_byte == next_seq) begin
        next_seq++;
        rpt_flags[KIND_ACTIVE] = 1'b1;
      end
      return;
    end
    // big-endian length of an initialisation report
    if (rpt_flags[KIND_INIT]) begin
      if (pos == CONT_HDR_BYTES) begin
        msg_length = {beat.report_byte, 8'h00};
        return;
      end
      if (pos == INIT_HDR_BYTES - 1) begin
        len = msg_length | {8'h00, beat.report_byte};
        msg_length = len;
        if (len > MAX_MESSAGE_BYTES) begin
          msg_left  = '0;
          rpt_flags = '0;
          return;
        end
        msg_channel = rpt_channel;
        next_seq    = '0;
        msg_offset  = '0;
        msg_left    = len[12:0];
        rpt_flags[KIND_ACTIVE] = 1'b1;
        return;
      end
    end
    if (!rpt_flags[KIND_ACTIVE] || msg_left == 0) return;
    msg_left--;
    res.channel_id     = msg_channel;
    res.command_code   = msg_command;
    res.message_length = msg_length[12:0];
    res.payload_byte   = beat.report_byte;
    res.byte_offset    = msg_offset;
    res.message_last   = (msg_left == 0);
    msg_offset++;
    expected_bytes.push_back(res);
  endtask

  function automatic int unsigned idle_span(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // report length for a report with a header of hdr bytes and need payload bytes left
  function automatic int unsigned report_len_for(input int unsigned hdr,
                                                 input int unsigned need);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return (hdr + need > REPORT_BYTES) ? REPORT_BYTES : hdr + need;
    if (r < 70) return REPORT_BYTES;
    if (r < 80) return $urandom_range(REPORT_BYTES + 1, 127);
    return $urandom_range(hdr, REPORT_BYTES - 1);
  endfunction

  function automatic int unsigned stray_count();
    return ($urandom_range(0, 11) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  task automatic push_beat(input logic [7:0] b, input bit first, input int unsigned rl);
    item_t it;
    it.report_byte     = b;
    it.first_of_report = first;
    it.report_length   = 7'(rl);
    pending_beats.push_back(it);
  endtask

  // one report: channel, type byte, length when it is an initialisation, random fill,
  // then a few stray bytes past its end
  task automatic push_report(input logic [31:0] chan, input logic [7:0] type_byte,
                             input logic [15:0] len_field, input int unsigned rl,
                             input int unsigned extra);
    int unsigned count;
    logic [7:0]  b;
    count = ((rl > REPORT_BYTES) ? REPORT_BYTES : rl) + extra;
    for (int i = 0; i < count; i++) begin
      if (i < CHAN_BYTES) b = chan[8*i +: 8];
      else if (i == CHAN_BYTES) b = type_byte;
      else if (type_byte[TYPE_INIT_BIT] && i == CONT_HDR_BYTES) b = len_field[15:8];
      else if (type_byte[TYPE_INIT_BIT] && i == INIT_HDR_BYTES - 1) b = len_field[7:0];
      else b = 8'($urandom);
      push_beat(b, i == 0, rl);
    end
  endtask

  // a whole message, optionally abandoned early or mixed with rejected continuations
  task automatic push_message(input logic [31:0] chan, input logic [7:0] cmd,
                              input int unsigned msg_len, input bit cut_short,
                              input bit noisy);
    int unsigned left;
    int unsigned rl;
    int unsigned eff;
    int unsigned seq;
    logic [7:0]  bad_seq;
    left = msg_len;
    seq  = 0;
    rl   = report_len_for(INIT_HDR_BYTES, left);
    push_report(chan, cmd, 16'(msg_len), rl, stray_count());
    eff  = (rl > REPORT_BYTES) ? REPORT_BYTES : rl;
    left = (left > eff - INIT_HDR_BYTES) ? left - (eff - INIT_HDR_BYTES) : 0;
    while (left > 0 && seq < 128) begin
      if (cut_short && $urandom_range(0, 2) == 0) return;
      if (noisy && $urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          // foreign channel with the right sequence number
          push_report(chan ^ (32'h1 << $urandom_range(0, 31)), 8'(seq), 16'h0,
                      report_len_for(CONT_HDR_BYTES, left), 0);
        end else begin
          bad_seq = 8'($urandom_range(0, 127));
          if (bad_seq == 8'(seq)) bad_seq = 8'((seq + 1) % 128);
          push_report(chan, bad_seq, 16'h0, report_len_for(CONT_HDR_BYTES, left), 0);
        end
      end
      rl = report_len_for(CONT_HDR_BYTES, left);
      push_report(chan, 8'(seq), 16'h0, rl, stray_count());
      eff  = (rl > REPORT_BYTES) ? REPORT_BYTES : rl;
      left = (left > eff - CONT_HDR_BYTES) ? left - (eff - CONT_HDR_BYTES) : 0;
      seq++;
    end
  endtask

  // input driver
  item_t       on_wire;
  int unsigned in_gap;
  bit          in_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_gap  = 0;
      in_calm = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) reassemble_beat(on_wire);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          on_wire = pending_beats.pop_front();
          in_ch.valid           <= 1'b1;
          in_ch.report_byte     <= on_wire.report_byte;
          in_ch.first_of_report <= on_wire.first_of_report;
          in_ch.report_length   <= on_wire.report_length;
          in_gap = idle_span(in_calm);
          if ($urandom_range(0, 149) == 0) in_calm = !in_calm;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  result_t     want_beat;
  int unsigned out_stall;
  bit          out_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
      out_calm  = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch($sformatf("payload byte %0h with nothing expected",
                                  out_ch.payload_byte));
        end else begin
          want_beat = expected_bytes.pop_front();
          check_field("channel_id", out_ch.channel_id, want_beat.channel_id);
          check_field("command_code", out_ch.command_code, want_beat.command_code);
          check_field("message_length", out_ch.message_length, want_beat.message_length);
          check_field("payload_byte", out_ch.payload_byte, want_beat.payload_byte);
          check_field("byte_offset", out_ch.byte_offset, want_beat.byte_offset);
          check_field("message_last", out_ch.message_last, want_beat.message_last);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall = idle_span(out_calm);
        if ($urandom_range(0, 149) == 0) out_calm = !out_calm;
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL hid_report_message_reassembler_unit");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned base;
    int unsigned r;
    int unsigned sel;
    int unsigned n;
    logic [31:0] chan;
    logic [31:0] last_chan;
    logic [7:0]  cmd;
    logic [15:0] lenv;

    rst_ni                = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.report_byte     = 8'h00;
    in_ch.first_of_report = 1'b0;
    in_ch.report_length   = 7'd1;
    out_ch.ready          = 1'b0;
    errors      = 0;
    idle_cycles = 0;
    msg_channel = '0;
    msg_command = '0;
    msg_length  = '0;
    msg_left    = '0;
    msg_offset  = '0;
    next_seq    = '0;
    rpt_index   = '0;
    rpt_flags   = '0;
    rpt_channel = '0;

    // directed: headless byte, one-byte message on an all-ones channel, short report,
    // zero length, length one past the maximum
    push_beat(8'hA5, 1'b0, REPORT_BYTES);
    push_report(32'hFFFF_FFFF, 8'hFF, 16'd1, 8, 0);
    push_report(32'h0000_0000, 8'h00, 16'h0, 3, 0);
    push_report(32'h0000_0000, 8'h80, 16'd0, INIT_HDR_BYTES, 0);
    push_report(32'h1234_5678, 8'hC1, 16'(MAX_MESSAGE_BYTES + 1), INIT_HDR_BYTES, 0);

    // every sequence number up to the point where the type byte reads as a new message
    last_chan = $urandom;
    push_report(last_chan, 8'hB0, 16'd61, INIT_HDR_BYTES, 0);
    for (int s = 0; s < 127; s++) push_report(last_chan, 8'(s), 16'h0, CONT_HDR_BYTES, 0);
    push_report(last_chan, 8'd127, 16'h0, REPORT_BYTES, 0);
    push_report(last_chan, 8'h80, 16'd3, 10, 0);

    // random mix, mostly well-formed messages
    base = pending_beats.size();
    while (pending_beats.size() - base < RANDOM_BEATS) begin
      r   = $urandom_range(0, 99);
      sel = $urandom_range(0, 99);
      if (sel < 30) chan = last_chan;
      else if (sel < 35) chan = 32'h0000_0000;
      else if (sel < 40) chan = 32'hFFFF_FFFF;
      else chan = $urandom;
      cmd = {1'b1, 7'($urandom)};
      if (r < 72) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) n = $urandom_range(1, 40);
        else if (sel < 92) n = $urandom_range(41, 200);
        else n = $urandom_range(201, 800);
        push_message(chan, cmd, n, r >= 60, $urandom_range(0, 3) == 0);
        last_chan = chan;
      end else if (r < 78) begin
        // short report, or an initialisation too short for its length field
        if ($urandom_range(0, 1) == 1)
          push_report(chan, 8'($urandom), 16'($urandom), $urandom_range(1, 4), 0);
        else
          push_report(chan, cmd, 16'($urandom_range(1, 50)), $urandom_range(5, 6), 0);
      end else if (r < 83) begin
        case ($urandom_range(0, 3))
          0:       lenv = 16'd0;
          1:       lenv = 16'($urandom_range(MAX_MESSAGE_BYTES + 1, 16'hFFFF));
          2:       lenv = 16'(MAX_MESSAGE_BYTES);
          default: lenv = 16'hFFFF;
        endcase
        push_report(chan, cmd, lenv, $urandom_range(INIT_HDR_BYTES, REPORT_BYTES), 0);
      end else if (r < 88) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) push_beat(8'($urandom), 1'b0, $urandom_range(1, 127));
      end else if (r < 93) begin
        // continuation that may find no message open
        push_report(chan, 8'($urandom_range(0, 127)), 16'h0,
                    report_len_for(CONT_HDR_BYTES, 8), 0);
      end else begin
        n = $urandom_range(5, 20);
        for (int i = 0; i < n; i++)
          push_beat(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(1, 127));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_beats.size() == 0 && !in_ch.valid);
    wait (expected_bytes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_bytes.size() != 0)
      note_mismatch($sformatf("%0d payload bytes never came out", expected_bytes.size()));
    if (errors == 0) begin
      $display("PASS hid_report_message_reassembler_unit");
    end else begin
      $display("FAIL hid_report_message_reassembler_unit");
    end
    $finish;
  end

endmodule
